### rtl/frst_pkg.sv
package frst_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned HZ_W        = 40;
  localparam int unsigned CLASS_W     = 5;
  localparam int unsigned MODE_W      = 4;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [HZ_W-1:0]    lower;
    logic [HZ_W-1:0]    upper;
    logic [CLASS_W-1:0] classes;
    logic [MODE_W-1:0]  modes;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [CLASS_W-1:0] classes;
    logic [MODE_W-1:0]  modes;
  } result_t;

endpackage

### rtl/frequency_range_table_search_core.sv
// Channel   Direction  Handshake           Payload
// request   in         start_i, busy_o     req_type_i, entry_index_i, lower_hz_i,
//                                          upper_hz_i, class_bits_i, mode_bits_i, freq_hz_i
// result    out        done_o              found_o, band_index_o, band_classes_o,
//                                          band_modes_o
// config    in         cfg_we_i            cfg_wdata_i (entry_count)
//
// A write item does not raise busy_o.
// A lookup makes at most log2(TABLE_DEPTH) + 1 table reads (11 for 1024 entries), none
// when entry_count is zero; each step is one read of the table RAM and one compare.
// done_o pulses in the cycle after the last compare; a new item may start in that cycle.
// Reset clears entry_count and the search control; the table contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module frequency_range_table_search_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [frst_pkg::COUNT_W-1:0]    cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [frst_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [frst_pkg::HZ_W-1:0]       lower_hz_i,
  input  logic [frst_pkg::HZ_W-1:0]       upper_hz_i,
  input  logic [frst_pkg::CLASS_W-1:0]    class_bits_i,
  input  logic [frst_pkg::MODE_W-1:0]     mode_bits_i,
  input  logic [frst_pkg::HZ_W-1:0]       freq_hz_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic [frst_pkg::INDEX_W-1:0]    band_index_o,
  output logic [frst_pkg::CLASS_W-1:0]    band_classes_o,
  output logic [frst_pkg::MODE_W-1:0]     band_modes_o
);

  logic [frst_pkg::COUNT_W-1:0] count_q;
  logic                         accept, wr_en, lk_start, busy, re;
  logic [frst_pkg::ADDR_W-1:0]  raddr;
  frst_pkg::entry_t             wdata, rdata;
  frst_pkg::result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign accept   = start_i && !busy;
  assign wr_en    = accept && (req_type_i == frst_pkg::REQ_WRITE)
                    && (32'(entry_index_i) < frst_pkg::TABLE_DEPTH);
  assign lk_start = accept && (req_type_i == frst_pkg::REQ_LOOKUP);

  assign wdata.lower   = lower_hz_i;
  assign wdata.upper   = upper_hz_i;
  assign wdata.classes = class_bits_i;
  assign wdata.modes   = mode_bits_i;

  frst_table u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (frst_pkg::ADDR_W'(entry_index_i)),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  frst_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lk_start),
    .freq_i   (freq_hz_i),
    .count_i  (count_q),
    .busy_o   (busy),
    .re_o     (re),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .done_o   (done_o),
    .result_o (result)
  );

  assign busy_o         = busy;
  assign found_o        = result.found;
  assign band_index_o   = result.index;
  assign band_classes_o = result.classes;
  assign band_modes_o   = result.modes;

endmodule

### rtl/frst_table.sv
module frst_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [frst_pkg::ADDR_W-1:0]   waddr_i,
  input  frst_pkg::entry_t              wdata_i,
  input  logic                          re_i,
  input  logic [frst_pkg::ADDR_W-1:0]   raddr_i,
  output frst_pkg::entry_t              rdata_o
);

  frst_pkg::entry_t mem_q [frst_pkg::TABLE_DEPTH];
  frst_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/frst_search.sv
module frst_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [frst_pkg::HZ_W-1:0]      freq_i,
  input  logic [frst_pkg::COUNT_W-1:0]   count_i,
  output logic                           busy_o,
  output logic                           re_o,
  output logic [frst_pkg::ADDR_W-1:0]    raddr_o,
  input  frst_pkg::entry_t               rdata_i,
  output logic                           done_o,
  output frst_pkg::result_t              result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SRCH
  } state_e;

  state_e                        state_q;
  logic [frst_pkg::HZ_W-1:0]     freq_q;
  logic [frst_pkg::COUNT_W-1:0]  lo_q, hi_q, mid_q;
  logic                          done_q;
  frst_pkg::result_t             result_q;

  logic [frst_pkg::COUNT_W-1:0]  hi0, mid0, lo_n, hi_n, mid_n;
  logic [frst_pkg::COUNT_W:0]    sum_n;
  logic                          below, above, hit, more;

  always_comb begin
    if (count_i > frst_pkg::COUNT_W'(frst_pkg::TABLE_DEPTH)) begin
      hi0 = frst_pkg::COUNT_W'(frst_pkg::TABLE_DEPTH);
    end else begin
      hi0 = count_i;
    end
    mid0  = hi0 >> 1;
    below = freq_q < rdata_i.lower;
    above = freq_q > rdata_i.upper;
    hit   = !below && !above;
    lo_n  = above ? mid_q + frst_pkg::COUNT_W'(1) : lo_q;
    hi_n  = below ? mid_q : hi_q;
    sum_n = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n = sum_n[frst_pkg::COUNT_W:1];
    more  = !hit && (lo_n < hi_n);
  end

  always_comb begin
    re_o    = 1'b0;
    raddr_o = frst_pkg::ADDR_W'(mid0);
    unique case (state_q)
      ST_IDLE: begin
        re_o    = start_i && (hi0 != '0);
        raddr_o = frst_pkg::ADDR_W'(mid0);
      end
      ST_SRCH: begin
        re_o    = more;
        raddr_o = frst_pkg::ADDR_W'(mid_n);
      end
      default: begin
        re_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      result_q <= '0;
      freq_q   <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            freq_q <= freq_i;
            lo_q   <= '0;
            hi_q   <= hi0;
            mid_q  <= mid0;
            if (hi0 == '0) begin
              done_q   <= 1'b1;
              result_q <= '0;
            end else begin
              state_q <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          mid_q <= mid_n;
          if (hit) begin
            done_q           <= 1'b1;
            result_q.found   <= 1'b1;
            result_q.index   <= frst_pkg::INDEX_W'(mid_q);
            result_q.classes <= rdata_i.classes;
            result_q.modes   <= rdata_i.modes;
            state_q          <= ST_IDLE;
          end else if (!more) begin
            done_q   <= 1'b1;
            result_q <= '0;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### tb/band_scoreboard_pkg.sv
package band_scoreboard_pkg;

  import frst_pkg::*;

  class band_scoreboard;
    entry_t                 bands [TABLE_DEPTH];
    logic [COUNT_W-1:0]     entry_count;
    result_t                lookup_q [$];
    int                     mismatches;

    function new();
      entry_count = '0;
      mismatches  = 0;
    endfunction

    function result_t search(logic [HZ_W-1:0] freq);
      result_t     res;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      bit          hit;
      res = '0;
      lo  = 0;
      hi  = entry_count;
      hit = 1'b0;
      if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
      while (lo < hi && !hit) begin
        mid = (lo + hi) / 2;
        if (freq < bands[mid].lower) begin
          hi = mid;
        end else if (freq > bands[mid].upper) begin
          lo = mid + 1;
        end else begin
          hit         = 1'b1;
          res.found   = 1'b1;
          res.index   = mid[INDEX_W-1:0];
          res.classes = bands[mid].classes;
          res.modes   = bands[mid].modes;
        end
      end
      return res;
    endfunction

    function void note_item(logic req, logic [INDEX_W-1:0] slot, logic [HZ_W-1:0] lower,
                            logic [HZ_W-1:0] upper, logic [CLASS_W-1:0] classes,
                            logic [MODE_W-1:0] modes, logic [HZ_W-1:0] freq);
      if (req == REQ_WRITE) begin
        bands[slot].lower   = lower;
        bands[slot].upper   = upper;
        bands[slot].classes = classes;
        bands[slot].modes   = modes;
      end else begin
        lookup_q.push_back(search(freq));
      end
    endfunction

    function void check_result(logic found, logic [INDEX_W-1:0] index,
                               logic [CLASS_W-1:0] classes, logic [MODE_W-1:0] modes);
      result_t want;
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d index=%0d classes=%0h modes=%0h",
                   found, index, classes, modes);
        return;
      end
      want = lookup_q.pop_front();
      if (found !== want.found || index !== want.index ||
          classes !== want.classes || modes !== want.modes) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want found=%0d index=%0d classes=%0h modes=%0h",
                   want.found, want.index, want.classes, want.modes);
          $display("          got  found=%0d index=%0d classes=%0h modes=%0h",
                   found, index, classes, modes);
        end
      end
    endfunction
  endclass

endpackage

### tb/testbench.sv
module testbench;

  import frst_pkg::*;
  import band_scoreboard_pkg::*;

  localparam int unsigned   CYCLE_LIMIT  = 1000000;
  localparam int unsigned   RANDOM_ITEMS = 950;
  localparam int unsigned   SETTLE       = 16;
  localparam logic [HZ_W-1:0] HZ_MAX     = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [COUNT_W-1:0]   cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic                 req_type_i;
  logic [INDEX_W-1:0]   entry_index_i;
  logic [HZ_W-1:0]      lower_hz_i;
  logic [HZ_W-1:0]      upper_hz_i;
  logic [CLASS_W-1:0]   class_bits_i;
  logic [MODE_W-1:0]    mode_bits_i;
  logic [HZ_W-1:0]      freq_hz_i;
  logic                 done_o;
  logic                 found_o;
  logic [INDEX_W-1:0]   band_index_o;
  logic [CLASS_W-1:0]   band_classes_o;
  logic [MODE_W-1:0]    band_modes_o;

  band_scoreboard       sb;
  int unsigned          cycles;

  frequency_range_table_search_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .lower_hz_i     (lower_hz_i),
    .upper_hz_i     (upper_hz_i),
    .class_bits_i   (class_bits_i),
    .mode_bits_i    (mode_bits_i),
    .freq_hz_i      (freq_hz_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .band_index_o   (band_index_o),
    .band_classes_o (band_classes_o),
    .band_modes_o   (band_modes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(found_o, band_index_o, band_classes_o, band_modes_o);
      if (cfg_we_i) sb.entry_count = cfg_wdata_i;
      if (start_i && !busy_o)
        sb.note_item(req_type_i, entry_index_i, lower_hz_i, upper_hz_i,
                     class_bits_i, mode_bits_i, freq_hz_i);
    end
  end

  function automatic logic [HZ_W-1:0] rand_hz();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[HZ_W-1:0];
  endfunction

  function automatic longint unsigned rand_between(longint unsigned a, longint unsigned b);
    longint unsigned v;
    v = {$urandom, $urandom};
    return a + (v % (b - a + 1));
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic entry_t make_band(logic [HZ_W-1:0] lower, logic [HZ_W-1:0] upper,
                                       logic [CLASS_W-1:0] classes, logic [MODE_W-1:0] modes);
    entry_t e;
    e.lower   = lower;
    e.upper   = upper;
    e.classes = classes;
    e.modes   = modes;
    return e;
  endfunction

  function automatic bit ordered_band(int k, output entry_t e);
    longint unsigned lo_b;
    longint unsigned hi_b;
    longint unsigned x;
    longint unsigned y;
    lo_b = (k == 0) ? 0 : longint'(sb.bands[k-1].upper) + 1;
    if (k == TABLE_DEPTH - 1) begin
      hi_b = HZ_MAX;
    end else begin
      if (sb.bands[k+1].lower == '0) return 1'b0;
      hi_b = longint'(sb.bands[k+1].lower) - 1;
    end
    if (lo_b > hi_b || hi_b > HZ_MAX) return 1'b0;
    x = rand_between(lo_b, hi_b);
    y = rand_between(lo_b, hi_b);
    if (x > y) e = make_band(y, x, $urandom_range(0, 31), $urandom_range(0, 15));
    else e = make_band(x, y, $urandom_range(0, 31), $urandom_range(0, 15));
    return 1'b1;
  endfunction

  function automatic logic [HZ_W-1:0] pick_freq();
    int unsigned eff;
    int unsigned k;
    int          r;
    eff = sb.entry_count;
    if (eff > TABLE_DEPTH) eff = TABLE_DEPTH;
    r = $urandom_range(0, 99);
    if (eff > 0 && r < 75) begin
      k = $urandom_range(0, eff - 1);
      if (r < 55 && sb.bands[k].lower <= sb.bands[k].upper)
        return rand_between(sb.bands[k].lower, sb.bands[k].upper);
      case ($urandom_range(0, 3))
        0: return sb.bands[k].lower;
        1: return sb.bands[k].upper;
        2: return sb.bands[k].lower - 1'b1;
        default: return sb.bands[k].upper + 1'b1;
      endcase
    end
    if (r < 95) return rand_hz();
    return ($urandom_range(0, 1) == 0) ? '0 : HZ_MAX;
  endfunction

  task automatic issue(logic req, logic [INDEX_W-1:0] slot, logic [HZ_W-1:0] lower,
                       logic [HZ_W-1:0] upper, logic [CLASS_W-1:0] classes,
                       logic [MODE_W-1:0] modes, logic [HZ_W-1:0] freq, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    req_type_i    <= req;
    entry_index_i <= slot;
    lower_hz_i    <= lower;
    upper_hz_i    <= upper;
    class_bits_i  <= classes;
    mode_bits_i   <= modes;
    freq_hz_i     <= freq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_band(int k, entry_t e, int gap);
    logic [INDEX_W-1:0] slot;
    slot = k[INDEX_W-1:0];
    issue(REQ_WRITE, slot, e.lower, e.upper, e.classes, e.modes, rand_hz(), gap);
  endtask

  task automatic lookup(logic [HZ_W-1:0] freq, int gap);
    issue(REQ_LOOKUP, $urandom_range(0, TABLE_DEPTH - 1), rand_hz(), rand_hz(),
          $urandom_range(0, 31), $urandom_range(0, 15), freq, gap);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.lookup_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_count(logic [COUNT_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned        issued;
    int                 seg;
    int                 seg_len;
    int                 bad_slot;
    int                 k;
    int                 r;
    bit                 calm;
    bit                 broken;
    logic [COUNT_W-1:0] cnt;
    longint unsigned    base;
    logic [HZ_W-1:0]    lower;
    logic [HZ_W-1:0]    upper;
    entry_t             saved;
    entry_t             e;

    sb            = new();
    cycles        = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start_i       = 1'b0;
    req_type_i    = REQ_WRITE;
    entry_index_i = '0;
    lower_hz_i    = '0;
    upper_hz_i    = '0;
    class_bits_i  = '0;
    mode_bits_i   = '0;
    freq_hz_i     = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset: every lookup misses
    lookup('0, 0);
    lookup(HZ_MAX, 2);

    write_band(0, make_band('0, 40'd99, 5'd31, 4'd15), 0);
    write_band(1, make_band(40'd200, 40'd100, 5'd1, 4'd1), 1);
    write_band(2, make_band(40'd1000, 40'd2000, 5'd0, 4'd0), 0);
    write_band(3, make_band(40'd5000, 40'd5000, 5'd21, 4'd10), 3);
    write_band(4, make_band(HZ_MAX - 40'd15, HZ_MAX, 5'd10, 4'd5), 0);
    set_count(5);
    lookup('0, 0);
    lookup(40'd99, 0);
    lookup(40'd100, 1);
    lookup(40'd150, 0);
    lookup(40'd1000, 5);
    lookup(40'd2000, 0);
    lookup(40'd2001, 0);
    lookup(40'd5000, 2);
    lookup(HZ_MAX, 0);
    lookup(HZ_MAX - 40'd15, 0);
    lookup(HZ_MAX - 40'd16, 30);
    lookup(40'd1500, 0);
    set_count(1);
    lookup(40'd50, 0);
    lookup(40'd1000, 1);

    // fill the whole table in ascending order with gaps between bands
    calm = 1'b0;
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (k % 128 == 0) calm = ($urandom_range(0, 1) == 0);
      base  = longint'(k) << 30;
      lower = (k == 0) ? '0 : base + ({$urandom} % (1 << 28));
      upper = (k == TABLE_DEPTH - 1) ? HZ_MAX : lower + ({$urandom} % (1 << 29));
      write_band(k, make_band(lower, upper, $urandom_range(0, 31), $urandom_range(0, 15)),
                 pick_gap(calm));
    end

    issued = 0;
    seg    = 0;
    while (issued < RANDOM_ITEMS) begin
      case (seg)
        0: cnt = 2047;
        1: cnt = 1024;
        2: cnt = 0;
        default: begin
          r = $urandom_range(0, 5);
          if (r == 0) cnt = 1;
          else if (r == 1) cnt = 2;
          else if (r == 2) cnt = 1023;
          else if (r == 3) cnt = $urandom_range(1025, 2047);
          else cnt = $urandom_range(3, 1024);
        end
      endcase
      set_count(cnt);
      seg_len  = $urandom_range(30, 70);
      calm     = ($urandom_range(0, 3) == 0);
      broken   = ($urandom_range(0, 6) == 0);
      bad_slot = $urandom_range(0, TABLE_DEPTH - 1);
      if (broken) begin
        saved = sb.bands[bad_slot];
        write_band(bad_slot, make_band(rand_hz(), rand_hz(), $urandom_range(0, 31),
                   $urandom_range(0, 15)), pick_gap(calm));
        issued++;
      end
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 49) == 0) drain();
        k = $urandom_range(0, TABLE_DEPTH - 1);
        if ($urandom_range(0, 3) == 0 && !(broken && k >= bad_slot - 1 && k <= bad_slot + 1)
            && ordered_band(k, e))
          write_band(k, e, pick_gap(calm));
        else
          lookup(pick_freq(), pick_gap(calm));
        issued++;
      end
      if (broken) begin
        write_band(bad_slot, saved, pick_gap(calm));
        issued++;
      end
      seg++;
    end

    drain();
    if (sb.mismatches == 0 && sb.lookup_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
